[hw/rtl/stp_pkg.sv]
package stp_pkg;

	localparam int POS_BITS = 24;
	localparam int FRAC_BITS = 10;
	localparam int DIV_BITS = 64;
	localparam int DCNT_BITS = 7;

	localparam logic [1:0] REQ_MOVE = 2'd0;
	localparam logic [1:0] REQ_TICK = 2'd1;
	localparam logic [1:0] REQ_UPDATE = 2'd2;
	localparam logic [1:0] REQ_STOP = 2'd3;

	localparam logic [2:0] REG_MAX_ACCEL = 3'd0;
	localparam logic [2:0] REG_MIN_SPEED = 3'd1;
	localparam logic [2:0] REG_RECAL_SPEED = 3'd2;
	localparam logic [2:0] REG_RECAL_DIST = 3'd3;
	localparam logic [2:0] REG_INVERT = 3'd4;
	localparam logic [2:0] REG_PERIOD_SCALE = 3'd5;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MOVE_SETUP,
		ST_RAMP_DIV,
		ST_RAMP_DONE,
		ST_SLOPE_DIV,
		ST_SLOPE_DONE,
		ST_UPD_SEL,
		ST_UPD_MUL,
		ST_UPD_PICK,
		ST_PER_DIV,
		ST_PER_DONE,
		ST_RESULT
	} state_t;

	typedef struct packed {
		logic load_move;
		logic ramp_div_start;
		logic ramp_store;
		logic slope_div_start;
		logic slope_store;
		logic upd_select;
		logic upd_mul;
		logic upd_pick;
		logic per_div_start;
		logic per_store;
		logic do_tick;
		logic do_stop;
		logic finish_move;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic div_busy;
		logic slope_zero;
		logic speed_zero;
	} sts_t;

endpackage

[hw/rtl/stp_if.sv]
interface stp_req_if;
	logic valid;
	logic ready;
	logic [1:0] req_type;
	logic signed [16:0] move_speed;
	logic [23:0] move_distance;
	logic recal_request;
	modport source (output valid, req_type, move_speed, move_distance, recal_request,
		input ready);
	modport sink (input valid, req_type, move_speed, move_distance, recal_request,
		output ready);
endinterface

interface stp_res_if;
	logic valid;
	logic ready;
	logic pulse_valid;
	logic pulse_level;
	logic direction_level;
	logic timer_active;
	logic [31:0] step_period;
	logic move_finished;
	logic recal_active;
	modport source (output valid, pulse_valid, pulse_level, direction_level, timer_active,
		step_period, move_finished, recal_active, input ready);
	modport sink (input valid, pulse_valid, pulse_level, direction_level, timer_active,
		step_period, move_finished, recal_active, output ready);
endinterface

[hw/rtl/stp_divider.sv]
// restoring divider, one quotient bit per cycle
module stp_divider (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [stp_pkg::DIV_BITS-1:0]   dividend,
	input  logic [stp_pkg::DIV_BITS-1:0]   divisor,
	output logic                           busy,
	output logic [stp_pkg::DIV_BITS-1:0]   quotient
);
	logic [stp_pkg::DIV_BITS-1:0] rem_q, quo_q, dsr_q;
	logic [stp_pkg::DCNT_BITS-1:0] cnt_q;
	logic busy_q;
	logic [stp_pkg::DIV_BITS:0] trial;
	logic [stp_pkg::DIV_BITS:0] shifted;

	assign shifted = {rem_q, quo_q[stp_pkg::DIV_BITS-1]};
	assign trial = shifted - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= stp_pkg::DCNT_BITS'(stp_pkg::DIV_BITS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == stp_pkg::DCNT_BITS'(1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			if (!trial[stp_pkg::DIV_BITS]) begin
				rem_q <= trial[stp_pkg::DIV_BITS-1:0];
				quo_q <= {quo_q[stp_pkg::DIV_BITS-2:0], 1'b1};
			end else begin
				rem_q <= shifted[stp_pkg::DIV_BITS-1:0];
				quo_q <= {quo_q[stp_pkg::DIV_BITS-2:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign quotient = quo_q;
endmodule

[hw/rtl/stp_datapath.sv]
module stp_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  stp_pkg::cmd_t       cmd,
	output stp_pkg::sts_t       sts,
	input  logic signed [16:0]  move_speed,
	input  logic [23:0]         move_distance,
	input  logic                recal_request,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_idx,
	input  logic [31:0]         cfg_data,
	output logic                o_pulse_valid,
	output logic                o_pulse_level,
	output logic                o_direction_level,
	output logic                o_timer_active,
	output logic [31:0]         o_step_period,
	output logic                o_move_finished,
	output logic                o_recal_active
);
	localparam int PB = stp_pkg::POS_BITS;
	localparam int DB = stp_pkg::DIV_BITS;
	localparam logic [PB-1:0] POS_MAX = '1;

	// profile phase picked by a speed update
	localparam logic [1:0] PH_RECAL = 2'd0;
	localparam logic [1:0] PH_ACCEL = 2'd1;
	localparam logic [1:0] PH_CRUISE = 2'd2;
	localparam logic [1:0] PH_DECEL = 2'd3;

	logic [15:0] max_accel_q, min_speed_q, recal_speed_q;
	logic [23:0] recal_dist_q;
	logic invert_q;
	logic [31:0] period_scale_q;

	logic [PB-1:0] pos_q, goal_q, ramp_q;
	logic [31:0] slope_q;
	logic [16:0] mag_q;
	logic cruise_neg_q, recal_req_q, recal_phase_q, timer_q, dir_q;
	logic [31:0] period_q;
	logic [16:0] speed_q;
	logic [1:0] phase_q;
	logic [PB-1:0] rdist_q;
	logic [47:0] prod_q;
	logic pv_q, pl_q;

	logic div_start, div_busy;
	logic [DB-1:0] div_a, div_b, div_q;

	// move setup combinational
	logic signed [17:0] spd;
	logic [16:0] mag_raw;
	logic [PB-1:0] dist_m;

	assign spd = {move_speed[16], move_speed};
	assign mag_raw = move_speed[16] ? 17'(-spd) : move_speed[16:0];
	always_comb begin
		dist_m = PB'(move_distance);
		if (recal_request)
			dist_m = (PB'(move_distance) > PB'(recal_dist_q))
				? PB'(move_distance) - PB'(recal_dist_q) : '0;
	end

	logic [33:0] c2m2;
	assign c2m2 = 34'(mag_q) * 34'(mag_q) - 34'(min_speed_q) * 34'(min_speed_q);

	always_comb begin
		div_start = 1'b0;
		div_a = '0;
		div_b = '0;
		if (cmd.ramp_div_start) begin
			div_start = 1'b1;
			div_a = DB'(c2m2);
			div_b = DB'({max_accel_q, 1'b0});
		end else if (cmd.slope_div_start) begin
			div_start = 1'b1;
			div_a = DB'(17'(mag_q - 17'(min_speed_q))) << stp_pkg::FRAC_BITS;
			div_b = DB'(ramp_q);
		end else if (cmd.per_div_start) begin
			div_start = 1'b1;
			div_a = DB'(period_scale_q);
			div_b = DB'(speed_q);
		end
	end

	stp_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_a),
		.divisor(div_b), .busy(div_busy), .quotient(div_q)
	);

	assign sts.div_busy = div_busy;
	assign sts.slope_zero = (ramp_q == '0);
	assign sts.speed_zero = (speed_q == '0);

	// speed update phase select
	logic [PB-1:0] cruise_end;
	assign cruise_end = goal_q - ramp_q;
	logic [PB+1:0] goal_ext;
	assign goal_ext = {2'b00, goal_q} + {1'b0, recal_dist_q, 1'b0};
	logic [16:0] ramp_spd;
	assign ramp_spd = 17'(32'(min_speed_q) + 32'(prod_q >> stp_pkg::FRAC_BITS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_accel_q <= 16'd1000;
			min_speed_q <= 16'd100;
			recal_speed_q <= 16'd100;
			recal_dist_q <= 24'd200;
			invert_q <= 1'b0;
			period_scale_q <= 32'd1000000;
			pos_q <= '1;
			goal_q <= '0;
			ramp_q <= '0;
			slope_q <= '0;
			mag_q <= '0;
			cruise_neg_q <= 1'b0;
			recal_req_q <= 1'b0;
			recal_phase_q <= 1'b0;
			timer_q <= 1'b0;
			dir_q <= 1'b0;
			period_q <= '0;
			phase_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					stp_pkg::REG_MAX_ACCEL: max_accel_q <= cfg_data[15:0];
					stp_pkg::REG_MIN_SPEED: min_speed_q <= cfg_data[15:0];
					stp_pkg::REG_RECAL_SPEED: recal_speed_q <= cfg_data[15:0];
					stp_pkg::REG_RECAL_DIST: recal_dist_q <= cfg_data[23:0];
					stp_pkg::REG_INVERT: invert_q <= cfg_data[0];
					stp_pkg::REG_PERIOD_SCALE: period_scale_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.load_move) begin
				recal_req_q <= recal_request;
				pos_q <= '0;
				goal_q <= {dist_m[PB-1:1], 1'b0};
				if (mag_raw < 17'(min_speed_q)) begin
					mag_q <= 17'(min_speed_q);
					cruise_neg_q <= !(spd > 0);
				end else begin
					mag_q <= mag_raw;
					cruise_neg_q <= spd < 0;
				end
			end
			if (cmd.ramp_store) begin
				if (max_accel_q == '0 || div_q > DB'(goal_q >> 1))
					ramp_q <= goal_q >> 1;
				else
					ramp_q <= PB'(div_q);
			end
			if (cmd.slope_store)
				slope_q <= sts.slope_zero ? '0 : div_q[31:0];
			if (cmd.upd_select) begin
				if (recal_phase_q && pos_q < goal_q)
					phase_q <= PH_RECAL;
				else if (pos_q < ramp_q)
					phase_q <= PH_ACCEL;
				else if (pos_q < cruise_end)
					phase_q <= PH_CRUISE;
				else if (pos_q < goal_q)
					phase_q <= PH_DECEL;
				else begin
					phase_q <= PH_CRUISE;
					recal_phase_q <= 1'b0;
				end
			end
			if (cmd.upd_pick && phase_q == PH_DECEL && recal_req_q &&
				ramp_spd <= 17'(recal_speed_q)) begin
				recal_phase_q <= 1'b1;
				goal_q <= (goal_ext[PB+1:PB] != 2'b00) ? POS_MAX : goal_ext[PB-1:0];
			end
			if (cmd.per_store)
				period_q <= div_q[31:0];
			if (cmd.finish_move) begin
				timer_q <= 1'b1;
				dir_q <= cruise_neg_q ^ invert_q;
			end
			if (cmd.do_tick && timer_q) begin
				if (pos_q < goal_q)
					pos_q <= pos_q + 1'b1;
				else
					timer_q <= 1'b0;
			end
			if (cmd.do_stop) begin
				recal_phase_q <= 1'b0;
				pos_q <= goal_q;
			end
		end
	end

	logic past_goal;
	assign past_goal = !(pos_q < goal_q);

	always_ff @(posedge clk) begin
		if (cmd.upd_select) begin
			rdist_q <= (pos_q < ramp_q) ? pos_q : goal_q - pos_q;
			speed_q <= '0;
		end
		if (cmd.upd_mul)
			prod_q <= 48'(slope_q) * 48'(rdist_q);
		if (cmd.upd_pick) begin
			priority if (phase_q == PH_RECAL)
				speed_q <= 17'(recal_speed_q);
			else if (phase_q == PH_ACCEL)
				speed_q <= ramp_spd;
			else if (phase_q == PH_CRUISE)
				speed_q <= past_goal ? '0 : mag_q;
			else
				speed_q <= (recal_req_q && ramp_spd <= 17'(recal_speed_q))
					? 17'(recal_speed_q) : ramp_spd;
		end
		if (cmd.upd_select || cmd.do_stop || cmd.load_move) begin
			pv_q <= 1'b0;
			pl_q <= 1'b0;
		end
		if (cmd.do_tick) begin
			pv_q <= timer_q && pos_q < goal_q;
			pl_q <= timer_q && pos_q < goal_q && !pos_q[0];
		end
	end

	assign o_pulse_valid = pv_q;
	assign o_pulse_level = pl_q;
	assign o_direction_level = dir_q;
	assign o_timer_active = timer_q;
	assign o_step_period = period_q;
	assign o_move_finished = past_goal;
	assign o_recal_active = recal_phase_q;
endmodule

[hw/rtl/stp_ctrl.sv]
module stp_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [1:0]      req_type,
	output logic            out_valid,
	input  logic            out_ready,
	input  stp_pkg::sts_t   sts,
	output stp_pkg::cmd_t   cmd
);
	stp_pkg::state_t state_q, state_d;
	logic move_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= stp_pkg::ST_IDLE;
			move_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == stp_pkg::ST_IDLE && in_valid)
				move_q <= (req_type == stp_pkg::REQ_MOVE);
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			stp_pkg::ST_IDLE: begin
				if (in_valid) begin
					unique case (req_type)
						stp_pkg::REQ_MOVE: state_d = stp_pkg::ST_MOVE_SETUP;
						stp_pkg::REQ_UPDATE: state_d = stp_pkg::ST_UPD_SEL;
						default: state_d = stp_pkg::ST_RESULT;
					endcase
				end
			end
			stp_pkg::ST_MOVE_SETUP: state_d = stp_pkg::ST_RAMP_DIV;
			stp_pkg::ST_RAMP_DIV: state_d = stp_pkg::ST_RAMP_DONE;
			stp_pkg::ST_RAMP_DONE: if (!sts.div_busy) state_d = stp_pkg::ST_SLOPE_DIV;
			stp_pkg::ST_SLOPE_DIV: state_d = stp_pkg::ST_SLOPE_DONE;
			stp_pkg::ST_SLOPE_DONE: if (!sts.div_busy) state_d = stp_pkg::ST_UPD_SEL;
			stp_pkg::ST_UPD_SEL: state_d = stp_pkg::ST_UPD_MUL;
			stp_pkg::ST_UPD_MUL: state_d = stp_pkg::ST_UPD_PICK;
			stp_pkg::ST_UPD_PICK: state_d = stp_pkg::ST_PER_DIV;
			stp_pkg::ST_PER_DIV: state_d = sts.speed_zero ? stp_pkg::ST_RESULT
				: stp_pkg::ST_PER_DONE;
			stp_pkg::ST_PER_DONE: if (!sts.div_busy) state_d = stp_pkg::ST_RESULT;
			stp_pkg::ST_RESULT: if (out_ready) state_d = stp_pkg::ST_IDLE;
			default: state_d = stp_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = (state_q == stp_pkg::ST_IDLE);
		out_valid = (state_q == stp_pkg::ST_RESULT);
		unique case (state_q)
			stp_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd.load_move = (req_type == stp_pkg::REQ_MOVE);
					cmd.do_tick = (req_type == stp_pkg::REQ_TICK);
					cmd.do_stop = (req_type == stp_pkg::REQ_STOP);
				end
			end
			stp_pkg::ST_RAMP_DIV: cmd.ramp_div_start = 1'b1;
			stp_pkg::ST_RAMP_DONE: cmd.ramp_store = !sts.div_busy;
			stp_pkg::ST_SLOPE_DIV: cmd.slope_div_start = 1'b1;
			stp_pkg::ST_SLOPE_DONE: cmd.slope_store = !sts.div_busy;
			stp_pkg::ST_UPD_SEL: cmd.upd_select = 1'b1;
			stp_pkg::ST_UPD_MUL: cmd.upd_mul = 1'b1;
			stp_pkg::ST_UPD_PICK: cmd.upd_pick = 1'b1;
			stp_pkg::ST_PER_DIV: begin
				cmd.per_div_start = !sts.speed_zero;
				cmd.finish_move = sts.speed_zero && move_q;
			end
			stp_pkg::ST_PER_DONE: begin
				cmd.per_store = !sts.div_busy;
				cmd.finish_move = !sts.div_busy && move_q;
			end
			default: ;
		endcase
	end
endmodule

[hw/rtl/stepper_trapezoid_profile.sv]
// Trapezoidal step-pulse profile generator. One result per request. A tick or
// stop request needs no divide; a speed update skips the period divide when
// the picked speed is zero. Moves and updates run on the shared 64-bit serial
// divider (one quotient bit a cycle) used for the ramp distance, the slope and
// the period. One request is in work at a time; the next is taken once the
// result is taken.
// Configuration writes go straight to the registers and must come while idle.
module stepper_trapezoid_profile (
	input  logic          clk,
	input  logic          arst_n,
	stp_req_if.sink       req,
	stp_res_if.source     res,
	input  logic          cfg_we,
	input  logic [2:0]    cfg_idx,
	input  logic [31:0]   cfg_data
);
	stp_pkg::cmd_t cmd;
	stp_pkg::sts_t sts;

	// controller: sequences setup, update and the divider passes
	stp_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(req.valid), .in_ready(req.ready), .req_type(req.req_type),
		.out_valid(res.valid), .out_ready(res.ready),
		.sts(sts), .cmd(cmd)
	);

	// datapath: profile state, config registers, multiplier and divider
	stp_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.move_speed(req.move_speed),
		.move_distance(req.move_distance), .recal_request(req.recal_request),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.o_pulse_valid(res.pulse_valid), .o_pulse_level(res.pulse_level),
		.o_direction_level(res.direction_level), .o_timer_active(res.timer_active),
		.o_step_period(res.step_period), .o_move_finished(res.move_finished),
		.o_recal_active(res.recal_active)
	);
endmodule

[hw/rtl/stp_checker.sv]
module stp_checker (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic res_valid,
	input logic res_ready,
	input logic pulse_valid,
	input logic pulse_level
);
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !req_ready) else $error("request taken while result pending");
	a_level_needs_valid: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && pulse_level |-> pulse_valid) else $error("pulse level without pulse");
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid) else $error("result dropped");
endmodule

bind stepper_trapezoid_profile stp_checker u_chk (
	.clk(clk), .arst_n(arst_n), .req_valid(req.valid), .req_ready(req.ready),
	.res_valid(res.valid), .res_ready(res.ready),
	.pulse_valid(res.pulse_valid), .pulse_level(res.pulse_level)
);

[tb/sv/testbench.sv]
`timescale 1ns / 100ps

module testbench;

	typedef struct packed {
		logic [1:0]         kind;
		logic signed [16:0] speed;
		logic [23:0]        distance;
		logic               recal;
	} step_req_t;

	typedef struct packed {
		logic        pulse_valid;
		logic        pulse_level;
		logic        direction_level;
		logic        timer_active;
		logic [31:0] step_period;
		logic        move_finished;
		logic        recal_active;
	} step_res_t;

	localparam logic [23:0] POS_MAX = 24'hFFFFFF;

	// profile predictor plus queue of expected results
	class profile_scoreboard;
		logic [15:0] max_accel, min_spd, recal_spd;
		logic [23:0] recal_dist;
		logic        invert;
		logic [31:0] scale;

		logic [23:0] pos, goal, ramp_dist;
		logic [31:0] slope, period;
		int          cruise;
		logic        recal_req, recal_ph, running, dir;

		step_res_t   pending[$];
		int          errors;
		int          checked;
		int          pulses;
		int          recal_seen;

		function new();
			max_accel = 1000;
			min_spd = 100;
			recal_spd = 100;
			recal_dist = 200;
			invert = 0;
			scale = 1000000;
			pos = POS_MAX;
			goal = 0;
			ramp_dist = 0;
			slope = 0;
			period = 0;
			cruise = 0;
			recal_req = 0;
			recal_ph = 0;
			running = 0;
			dir = 0;
			errors = 0;
			checked = 0;
			pulses = 0;
			recal_seen = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [31:0] data);
			case (idx)
				stp_pkg::REG_MAX_ACCEL: max_accel = data[15:0];
				stp_pkg::REG_MIN_SPEED: min_spd = data[15:0];
				stp_pkg::REG_RECAL_SPEED: recal_spd = data[15:0];
				stp_pkg::REG_RECAL_DIST: recal_dist = data[23:0];
				stp_pkg::REG_INVERT: invert = data[0];
				stp_pkg::REG_PERIOD_SCALE: scale = data;
				default: ;
			endcase
		endfunction

		// speed on a ramp, d half-steps from its slow end
		function logic [31:0] ramp_speed(logic [23:0] d);
			logic [63:0] prod;
			prod = 64'(slope) * 64'(d);
			return 32'(min_spd) + prod[stp_pkg::FRAC_BITS +: 32];
		endfunction

		function void speed_update();
			logic [31:0] spd;
			logic [23:0] cruise_end;
			logic [63:0] ext;
			cruise_end = goal - ramp_dist;
			if (recal_ph && pos < goal) begin
				spd = 32'(recal_spd);
			end else if (pos < ramp_dist) begin
				spd = ramp_speed(pos);
			end else if (pos < cruise_end) begin
				spd = cruise < 0 ? 32'(-cruise) : 32'(cruise);
			end else if (pos < goal) begin
				spd = ramp_speed(goal - pos);
				// slow enough near the end: switch to the wall approach
				if (recal_req && spd <= 32'(recal_spd)) begin
					ext = 64'(goal) + 64'(recal_dist) * 2;
					spd = 32'(recal_spd);
					recal_ph = 1;
					goal = ext > 64'(POS_MAX) ? POS_MAX : ext[23:0];
				end
			end else begin
				spd = 0;
				recal_ph = 0;
			end
			if (spd != 0)
				period = scale / spd;
		endfunction

		function void start_move(logic signed [16:0] raw_spd, logic [23:0] raw_dist, logic r);
			int          sp;
			logic [31:0] mag;
			logic [23:0] d;
			logic [63:0] c2, m2, ramp;
			sp = int'(raw_spd);
			d = raw_dist;
			recal_req = r;
			if (r)
				d = d > recal_dist ? d - recal_dist : 24'd0;
			pos = 0;
			mag = sp < 0 ? 32'(-sp) : 32'(sp);
			// a speed of zero takes the negative sign here
			if (mag < 32'(min_spd)) begin
				cruise = sp > 0 ? int'(min_spd) : -int'(min_spd);
				mag = 32'(min_spd);
			end else begin
				cruise = sp;
			end
			goal = {d[23:1], 1'b0};
			c2 = 64'(mag) * 64'(mag);
			m2 = 64'(min_spd) * 64'(min_spd);
			if (max_accel == 0)
				ramp = 64'(goal / 2);
			else
				ramp = (c2 - m2) / (64'(max_accel) * 2);
			if (ramp > 64'(goal / 2))
				ramp = 64'(goal / 2);
			ramp_dist = ramp[23:0];
			slope = ramp_dist == 0 ? 32'd0 :
				32'((64'(mag - 32'(min_spd)) << stp_pkg::FRAC_BITS) / 64'(ramp_dist));
			speed_update();
			running = 1;
			dir = (cruise < 0) ^ invert;
		endfunction

		function void note_request(step_req_t rq);
			step_res_t e;
			e = '0;
			case (rq.kind)
				stp_pkg::REQ_MOVE: start_move(rq.speed, rq.distance, rq.recal);
				stp_pkg::REQ_TICK: begin
					if (running) begin
						if (pos < goal) begin
							e.pulse_valid = 1;
							e.pulse_level = ~pos[0];
							pos = pos + 1;
						end else begin
							running = 0;
						end
					end
				end
				stp_pkg::REQ_UPDATE: speed_update();
				default: begin
					recal_ph = 0;
					pos = goal;
				end
			endcase
			e.direction_level = dir;
			e.timer_active = running;
			e.step_period = period;
			e.move_finished = pos >= goal;
			e.recal_active = recal_ph;
			pending.push_back(e);
		endfunction

		task report(string what, logic [31:0] got, logic [31:0] want);
			errors++;
			$display("mismatch at %0t, result %0d: %s got %0h want %0h",
				$time, checked, what, got, want);
		endtask

		task check_result(step_res_t got);
			step_res_t want;
			if (pending.size() == 0) begin
				report("unexpected result", 1, 0);
				return;
			end
			want = pending.pop_front();
			if (got.pulse_valid !== want.pulse_valid)
				report("pulse_valid", got.pulse_valid, want.pulse_valid);
			if (got.pulse_level !== want.pulse_level)
				report("pulse_level", got.pulse_level, want.pulse_level);
			if (got.direction_level !== want.direction_level)
				report("direction_level", got.direction_level, want.direction_level);
			if (got.timer_active !== want.timer_active)
				report("timer_active", got.timer_active, want.timer_active);
			if (got.step_period !== want.step_period)
				report("step_period", got.step_period, want.step_period);
			if (got.move_finished !== want.move_finished)
				report("move_finished", got.move_finished, want.move_finished);
			if (got.recal_active !== want.recal_active)
				report("recal_active", got.recal_active, want.recal_active);
			pulses += want.pulse_valid;
			recal_seen += want.recal_active;
			checked++;
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_idx;
	logic [31:0] cfg_data;

	stp_req_if req ();
	stp_res_if res ();

	stepper_trapezoid_profile DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req.sink),
		.res      (res.source),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	profile_scoreboard sb = new();

	// idling percentages of the current phase
	int send_idle_pct;
	int recv_stall_pct;
	// long hold-off of the receiver, asked by the stimulus and counted below
	logic long_hold_ask;
	int   hold_left;
	int   sent;
	int   moves;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// run limit, far above the slowest legal run
	initial begin
		#40ms;
		$display("RESULT: ERROR");
		$finish;
	end

	// result side: ready with random stalls, plus the long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.ready <= 0;
			hold_left <= 0;
		end else if (long_hold_ask && hold_left == 0) begin
			hold_left <= 400;
			res.ready <= 0;
		end else if (hold_left > 1) begin
			hold_left <= hold_left - 1;
			res.ready <= 0;
		end else begin
			hold_left <= 0;
			res.ready <= $urandom_range(0, 99) >= recv_stall_pct;
		end
	end

	// results are compared as they are taken
	always @(posedge clk) begin
		if (arst_n && res.valid && res.ready)
			sb.check_result({res.pulse_valid, res.pulse_level, res.direction_level,
				res.timer_active, res.step_period, res.move_finished, res.recal_active});
	end

	// one request, after a random gap; valid stays up into the next request
	task send(step_req_t rq);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			req.valid <= 0;
			@(posedge clk);
			while ($urandom_range(0, 99) < send_idle_pct)
				@(posedge clk);
		end
		req.valid <= 1;
		req.req_type <= rq.kind;
		req.move_speed <= rq.speed;
		req.move_distance <= rq.distance;
		req.recal_request <= rq.recal;
		do
			@(posedge clk);
		while (!req.ready);
		sb.note_request(rq);
		sent++;
		if (rq.kind == stp_pkg::REQ_MOVE)
			moves++;
	endtask

	task send_fields(logic [1:0] kind, int spd, logic [23:0] len, logic r);
		step_req_t rq;
		rq.kind = kind;
		rq.speed = 17'(spd);
		rq.distance = len;
		rq.recal = r;
		send(rq);
	endtask

	// waits out the results still owed, then lets the block settle
	task drain();
		req.valid <= 0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task write_reg(logic [2:0] idx, logic [31:0] data);
		cfg_we <= 1;
		cfg_idx <= idx;
		cfg_data <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
	endtask

	task write_all(logic [31:0] acc, logic [31:0] mn, logic [31:0] rs,
		logic [31:0] rd, logic [31:0] inv, logic [31:0] scl);
		write_reg(stp_pkg::REG_MAX_ACCEL, acc);
		write_reg(stp_pkg::REG_MIN_SPEED, mn);
		write_reg(stp_pkg::REG_RECAL_SPEED, rs);
		write_reg(stp_pkg::REG_RECAL_DIST, rd);
		write_reg(stp_pkg::REG_INVERT, inv);
		write_reg(stp_pkg::REG_PERIOD_SCALE, scl);
		cfg_we <= 0;
	endtask

	function automatic int rand_speed();
		int s;
		case ($urandom_range(0, 5))
			0: s = 0;
			1: s = $urandom_range(0, 300);
			2: begin
				s = int'($signed(17'($urandom)));
				if (s == -65536)
					s = -65535;
				return s;
			end
			3: s = 65535;
			default: s = $urandom_range(0, 3000);
		endcase
		return $urandom_range(0, 1) ? -s : s;
	endfunction

	function automatic logic [23:0] rand_dist();
		int r;
		r = $urandom_range(0, 99);
		if (r < 85)
			return 24'($urandom_range(0, 100));
		if (r < 95)
			return 24'($urandom_range(0, 400));
		return 24'($urandom);
	endfunction

	// a move followed by ticks and updates; now and then a stop or junk
	task move_sequence(int budget);
		int len;
		int r;
		step_req_t junk;
		send_fields(stp_pkg::REQ_MOVE, rand_speed(), rand_dist(),
			$urandom_range(0, 99) < 35);
		len = $urandom_range(5, 150);
		for (int k = 0; k < len && k < budget; k++) begin
			r = $urandom_range(0, 99);
			junk = $bits(step_req_t)'({$urandom, $urandom});
			if (junk.speed == 17'h10000)
				junk.speed = 17'h0FFFF;
			if (r < 55)
				junk.kind = stp_pkg::REQ_TICK;
			else if (r < 90)
				junk.kind = stp_pkg::REQ_UPDATE;
			else if (r < 94)
				junk.kind = stp_pkg::REQ_STOP;
			send(junk);
		end
	endtask

	task random_phase(int count, int mode, bit bool_hold);
		int start;
		start = sent;
		case (mode)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
			default: begin send_idle_pct = 19; recv_stall_pct = 19; end
		endcase
		while (sent - start < count) begin
			// long receiver hold-off while requests keep coming
			if (bool_hold && sent - start > count / 2) begin
				long_hold_ask <= 1;
				@(posedge clk);
				long_hold_ask <= 0;
				bool_hold = 0;
			end
			move_sequence(count - (sent - start));
		end
		drain();
	endtask

	initial begin
		arst_n = 0;
		cfg_we = 0;
		cfg_idx = 0;
		cfg_data = 0;
		req.valid = 0;
		req.req_type = stp_pkg::REQ_TICK;
		req.move_speed = 0;
		req.move_distance = 0;
		req.recal_request = 0;
		long_hold_ask = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		sent = 0;
		moves = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: reset values, tick and update before any move
		send_fields(stp_pkg::REQ_TICK, 0, 0, 0);
		send_fields(stp_pkg::REQ_UPDATE, 0, 0, 0);
		// fastest move over the longest distance, then stop it
		send_fields(stp_pkg::REQ_MOVE, 65535, 24'hFFFFFF, 0);
		send_fields(stp_pkg::REQ_TICK, 0, 0, 0);
		send_fields(stp_pkg::REQ_UPDATE, 0, 0, 0);
		send_fields(stp_pkg::REQ_STOP, 0, 0, 0);
		send_fields(stp_pkg::REQ_TICK, 0, 0, 0);
		send_fields(stp_pkg::REQ_TICK, 0, 0, 0);
		// full reverse speed, empty move
		send_fields(stp_pkg::REQ_MOVE, -65535, 0, 0);
		send_fields(stp_pkg::REQ_TICK, 0, 0, 0);
		// zero speed with recal distance bigger than the move
		send_fields(stp_pkg::REQ_MOVE, 0, 24'd5, 1);
		send_fields(stp_pkg::REQ_UPDATE, 0, 0, 0);
		// speed under the minimum, short move with recal and full decel
		send_fields(stp_pkg::REQ_MOVE, 50, 24'd401, 1);
		for (int k = 0; k < 6; k++) begin
			send_fields(stp_pkg::REQ_TICK, 0, 0, 0);
			send_fields(stp_pkg::REQ_UPDATE, 0, 0, 0);
		end
		drain();

		// zero acceleration, zero minimum, fastest recal with no distance, inverted, largest scale
		write_all(0, 0, 65535, 0, 1, 32'hFFFFFFFF);
		random_phase(300, 0, 0);
		// largest acceleration and minimum, recal goal saturating, smallest scale
		write_all(65535, 65535, 0, 24'hFFFFFF, 0, 1);
		random_phase(150, 1, 0);
		for (int p = 0; p < 5; p++) begin
			write_all($urandom_range(1, 3000), $urandom_range(0, 300),
				$urandom_range(0, 400), $urandom_range(0, 40), $urandom_range(0, 1),
				$urandom_range(0, 1) ? $urandom : $urandom_range(1000, 5000000));
			random_phase(280, (p + 2) % 4, p == 1);
		end

		if (sb.pending.size() != 0)
			sb.report("results missing", sb.pending.size(), 0);
		$display("covered %0d requests (%0d moves), %0d results checked", sent, moves,
			sb.checked);
		$display("saw %0d step pulses and %0d results in the recal phase", sb.pulses,
			sb.recal_seen);
		if (sb.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
